FILE: rtl/bdpd_pkg.sv
// Package: field widths, register indexes and result type for the switch debouncer.
package bdpd_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned VAL_W      = 32;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 104;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ENABLE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMALLY_CLOSED    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_DELAY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION_THRESHOLD = 3'd4;

	typedef struct packed {
		logic [VAL_W-1:0] press_total;
		logic             pressed_now;
		logic             duration_event;
		logic [VAL_W-1:0] released_duration;
		logic             release_event;
		logic             press_event;
		logic [VAL_W-1:0] held_duration;
	} result_t;

endpackage

FILE: rtl/button_debounce_with_press_duration_top.sv
// Top level: switch debouncer with press counter and press-duration timer.
//
// Channel  Dir  Handshake                Payload
// s_axis   in   s_axis_tvalid/tready     tdata: raw_level[0], now_time[32:1]
// m_axis   out  m_axis_tvalid/tready     tdata: result_t, 100 bits, zero padded
// cfg      in   cfg_wr_en                cfg_index, cfg_wdata
//
// One transaction per clock sustained while m_axis_tready is high; path: input register, result register.
// The whole debounce step (one subtraction, seven compares, counter increment) is between them.
// A transaction taken while block_enable is 0 produces no result and leaves state alone.
// arst_n clears control state and loads register reset values.
// m_axis_tready low holds the result register and stalls the input register behind it.
module button_debounce_with_press_duration_top
	import bdpd_pkg::*;
#(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // raw_level, now_time
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // held_duration, press_event, release_event,
	                                             // released_duration, duration_event,
	                                             // pressed_now, press_total
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned CW = (TIME_BITS > VAL_W) ? TIME_BITS : VAL_W;

	logic             block_enable_q;
	logic             active_low_q;
	logic             normally_closed_q;
	logic [VAL_W-1:0] debounce_delay_q;
	logic [VAL_W-1:0] duration_threshold_q;

	logic                 last_level_q;
	logic                 debounced_pressed_q;
	logic [TIME_BITS-1:0] change_stamp_q;
	logic [VAL_W-1:0]     press_counter_q;
	logic [VAL_W-1:0]     single_shot_mark_q;
	logic [TIME_BITS-1:0] current_hold_time_q;

	logic                 valid_s1;
	logic                 level_s1;
	logic [TIME_BITS-1:0] now_s1;

	logic    out_valid_q;
	result_t out_q;

	logic advance;
	logic fire;

	logic                 level;
	logic                 last_level_d;
	logic                 debounced_pressed_d;
	logic [TIME_BITS-1:0] change_stamp_d;
	logic [VAL_W-1:0]     press_counter_d;
	logic [VAL_W-1:0]     single_shot_mark_d;
	logic [TIME_BITS-1:0] current_hold_time_d;
	logic [TIME_BITS-1:0] elapsed;
	logic [TIME_BITS-1:0] held;
	result_t              res;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign fire          = valid_s1 && advance && block_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_enable_q       <= 1'b0;
			active_low_q         <= 1'b1;
			normally_closed_q    <= 1'b0;
			debounce_delay_q     <= '0;
			duration_threshold_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BLOCK_ENABLE:       block_enable_q       <= cfg_wdata[0];
				REG_ACTIVE_LOW:         active_low_q         <= cfg_wdata[0];
				REG_NORMALLY_CLOSED:    normally_closed_q    <= cfg_wdata[0];
				REG_DEBOUNCE_DELAY:     debounce_delay_q     <= cfg_wdata[VAL_W-1:0];
				REG_DURATION_THRESHOLD: duration_threshold_q <= cfg_wdata[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			level_s1 <= s_axis_tdata[0];
			now_s1   <= TIME_BITS'(s_axis_tdata[VAL_W:1]);
		end
	end

	always_comb begin
		level               = level_s1 ^ active_low_q ^ normally_closed_q;
		last_level_d        = last_level_q;
		debounced_pressed_d = debounced_pressed_q;
		change_stamp_d      = change_stamp_q;
		press_counter_d     = press_counter_q;
		single_shot_mark_d  = single_shot_mark_q;
		current_hold_time_d = current_hold_time_q;
		elapsed             = now_s1 - change_stamp_q;
		held                = '0;
		res                 = '0;

		if (level != last_level_q) begin
			last_level_d   = level;
			change_stamp_d = now_s1;
		end else if (CW'(elapsed) > CW'(debounce_delay_q)) begin
			if (debounced_pressed_q != last_level_q) begin
				debounced_pressed_d = last_level_q;
				if (last_level_q) begin
					press_counter_d = press_counter_q + 1'b1;
					res.press_event = 1'b1;
				end else begin
					res.release_event     = 1'b1;
					res.released_duration = VAL_W'(current_hold_time_q);
				end
			end
			held = debounced_pressed_d ? elapsed : '0;
			if (held != '0) begin
				current_hold_time_d = held;
				if (duration_threshold_q == '0) begin
					res.duration_event = 1'b1;
				end else if (CW'(held) >= CW'(duration_threshold_q) &&
				             single_shot_mark_q != press_counter_d) begin
					single_shot_mark_d = press_counter_d;
					res.duration_event = 1'b1;
				end
			end
		end

		res.held_duration = VAL_W'(held);
		res.pressed_now   = debounced_pressed_d;
		res.press_total   = press_counter_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q        <= 1'b0;
			debounced_pressed_q <= 1'b0;
			change_stamp_q      <= '0;
			press_counter_q     <= '0;
			single_shot_mark_q  <= '0;
			current_hold_time_q <= '0;
		end else if (fire) begin
			last_level_q        <= last_level_d;
			debounced_pressed_q <= debounced_pressed_d;
			change_stamp_q      <= change_stamp_d;
			press_counter_q     <= press_counter_d;
			single_shot_mark_q  <= single_shot_mark_d;
			current_hold_time_q <= current_hold_time_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_q);

endmodule
